// ===== hdl/bvrs_pkg.sv =====
package bvrs_pkg;

  localparam int WORD_BITS   = 32;
  localparam int MAX_WORDS   = 1024;
  localparam int COARSE_BITS = 256;
  localparam int FINE_BITS   = 8;
  localparam int CAP_BITS    = MAX_WORDS * WORD_BITS;
  localparam int COARSE_DEPTH = CAP_BITS / COARSE_BITS + 1;
  localparam int FINE_DEPTH   = CAP_BITS / FINE_BITS + 1;
  localparam int WADDR_W = $clog2(MAX_WORDS);
  localparam int CADDR_W = $clog2(COARSE_DEPTH);
  localparam int FADDR_W = $clog2(FINE_DEPTH);

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_RANK   = 2'd1,
    ACT_SELECT = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, b[i]};
    end
    return n;
  endfunction

  // Offset (MSB first) of the need-th one in the byte.
  function automatic logic [2:0] nth_one(input logic [7:0] b, input logic [3:0] need);
    logic [3:0] n;
    logic [2:0] idx;
    n = 4'd0;
    idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, b[7 - i]};
      if (b[7 - i] && n == need) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hdl/bvrs_if.sv =====
interface bvrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] word;
  logic [15:0] query_value;
  modport source (output valid, action, word, query_value, input ready);
  modport sink (input valid, action, word, query_value, output ready);
endinterface

interface bvrs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] answer;
  logic        error;
  modport source (output valid, answer, error, input ready);
  modport sink (input valid, answer, error, output ready);
endinterface

// ===== hdl/bit_vector_rank_select.sv =====
// Bit vector with rank and select queries.
// in_ch carries one transaction per item: action 0 appends a 32-bit word (MSB
// first), action 1 asks rank(query_value), action 2 asks select(query_value).
// out_ch returns one transaction per item: answer and error.
// The vector, the coarse directory (ones before every 256-bit block) and the
// fine directory (ones within the block before every byte) live in three
// single-port synchronous RAMs with registered reads.
// One item is handled at a time; in_ch.ready is high only while idle.
// Steps per item: append writes the fine directory once per byte plus once at
// the end boundary; rank does one parallel read of all three RAMs; select runs
// a binary search over the coarse directory, then one over the fine directory,
// then reads the word and scans its byte; errors and select of zero go straight to the response.
// The result waits in an output register and holds there while out_ch stalls.
// The next item may still be accepted and worked on; its result holds until
// the output register empties.
// Reset clears the word count and the one count; RAM contents are not cleared,
// and a RAM value read before being written is never used.
module bit_vector_rank_select (
  input logic clk,
  input logic rst_n,
  bvrs_in_if.sink    in_ch,
  bvrs_out_if.source out_ch
);
  import bvrs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_APP, S_RANK_RD, S_RANK_SUM, S_SEL_C, S_SEL_CCMP,
    S_SEL_F, S_SEL_FCMP, S_SEL_WRD, S_SEL_SCAN, S_RESP
  } state_t;

  logic [31:0] bit_mem [MAX_WORDS];
  logic [15:0] coarse_mem [COARSE_DEPTH];
  logic [7:0]  fine_mem [FINE_DEPTH];

  state_t      state_r;
  logic [31:0] word_r;
  logic [15:0] qv_r;
  logic [10:0] words_r;
  logic [15:0] ones_r;
  logic [8:0]  blk_r;
  logic [2:0]  step_r;
  logic [12:0] lo_r, hi_r, mid_r;
  logic [15:0] ck_r;
  logic [7:0]  cf_r;
  logic [15:0] ans_r;
  logic        err_r;
  logic        out_valid_r;
  logic [15:0] out_ans_r;
  logic        out_err_r;

  logic [31:0] b_rd;
  logic [15:0] c_rd;
  logic [7:0]  f_rd;

  logic [WADDR_W-1:0] b_addr;
  logic [CADDR_W-1:0] c_addr;
  logic [FADDR_W-1:0] f_addr;
  logic        b_we, c_we, f_we;
  logic [15:0] c_wdata;
  logic [7:0]  f_wdata;

  logic [15:0] len;
  logic [15:0] app_pos;
  logic        app_bnd;
  logic [8:0]  blk_eff;
  logic [7:0]  app_byte;
  logic [3:0]  app_pc;
  logic [12:0] mid_nxt;
  logic [7:0]  rk_byte;
  logic [15:0] rk_sum;
  logic [12:0] fbase;
  logic [12:0] fmax;
  logic [7:0]  sc_byte;
  logic [15:0] need_full;
  logic        in_acc;

  assign len     = {words_r, 5'd0};
  assign app_pos = len + {11'd0, step_r[1:0], 3'd0} + (step_r[2] ? 16'd32 : 16'd0);
  assign app_bnd = (app_pos[7:0] == 8'd0);
  assign blk_eff = app_bnd ? 9'd0 : blk_r;
  assign app_byte = word_r[8*(3 - step_r[1:0]) +: 8];
  assign app_pc  = popcount8(app_byte);
  assign mid_nxt = 13'((14'(lo_r) + 14'(hi_r) + 14'd1) >> 1);
  assign rk_byte = b_rd[8*(3 - qv_r[4:3]) +: 8] & ~(8'hFF >> qv_r[2:0]);
  assign rk_sum  = ((qv_r[15:8] == 8'd0) ? 16'd0 : c_rd)
                 + {8'd0, ((qv_r[7:3] == 5'd0) ? 8'd0 : f_rd)}
                 + {12'd0, popcount8(rk_byte)};
  assign fbase   = {lo_r[7:0], 5'd0};
  assign fmax    = ((fbase + 13'd31) < {words_r, 2'd0}) ? (fbase + 13'd31) : {words_r, 2'd0};
  assign sc_byte = b_rd[8*(3 - lo_r[1:0]) +: 8];
  assign need_full = qv_r - ck_r - {8'd0, cf_r};
  assign in_acc  = in_ch.valid && in_ch.ready;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.answer = out_ans_r;
  assign out_ch.error  = out_err_r;

  always_comb begin
    b_we = 1'b0;
    c_we = 1'b0;
    f_we = 1'b0;
    b_addr = lo_r[11:2];
    c_addr = mid_r[CADDR_W-1:0];
    f_addr = mid_r;
    c_wdata = ones_r;
    f_wdata = blk_eff[7:0];
    case (state_r)
      S_APP: begin
        b_we = (step_r == 3'd0);
        b_addr = words_r[WADDR_W-1:0];
        c_we = app_bnd;
        c_addr = app_pos[15:8];
        f_we = 1'b1;
        f_addr = app_pos[15:3];
      end
      S_RANK_RD: begin
        b_addr = qv_r[14:5];
        c_addr = qv_r[15:8];
        f_addr = qv_r[15:3];
      end
      S_SEL_C: c_addr = mid_nxt[CADDR_W-1:0];
      S_SEL_F: f_addr = mid_nxt;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (b_we) bit_mem[b_addr] <= word_r;
    b_rd <= bit_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) coarse_mem[c_addr] <= c_wdata;
    c_rd <= coarse_mem[c_addr];
  end

  always_ff @(posedge clk) begin
    if (f_we) fine_mem[f_addr] <= f_wdata;
    f_rd <= fine_mem[f_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      words_r <= '0;
      ones_r <= '0;
      blk_r <= '0;
      step_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_RESP) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            word_r <= in_ch.word;
            qv_r <= in_ch.query_value;
            step_r <= '0;
            ans_r <= '0;
            err_r <= 1'b0;
            lo_r <= '0;
            hi_r <= {5'd0, words_r[10:3]};
            ck_r <= '0;
            cf_r <= '0;
            case (action_t'(in_ch.action))
              ACT_APPEND: begin
                if (words_r == 11'(MAX_WORDS)) begin
                  ans_r <= len;
                  err_r <= 1'b1;
                  state_r <= S_RESP;
                end else begin
                  state_r <= S_APP;
                end
              end
              ACT_RANK: begin
                if (in_ch.query_value > len) begin
                  err_r <= 1'b1;
                  state_r <= S_RESP;
                end else begin
                  state_r <= S_RANK_RD;
                end
              end
              ACT_SELECT: begin
                if (in_ch.query_value > ones_r) begin
                  err_r <= 1'b1;
                  state_r <= S_RESP;
                end else if (in_ch.query_value == 16'd0) begin
                  state_r <= S_RESP;
                end else begin
                  state_r <= S_SEL_C;
                end
              end
              default: begin
                err_r <= 1'b1;
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_APP: begin
          if (step_r[2]) begin
            words_r <= words_r + 11'd1;
            blk_r <= blk_eff;
            ans_r <= app_pos;
            state_r <= S_RESP;
          end else begin
            ones_r <= ones_r + {12'd0, app_pc};
            blk_r <= blk_eff + {5'd0, app_pc};
            step_r <= step_r + 3'd1;
          end
        end
        S_RANK_RD: state_r <= S_RANK_SUM;
        S_RANK_SUM: begin
          ans_r <= rk_sum;
          state_r <= S_RESP;
        end
        S_SEL_C: begin
          if (lo_r < hi_r) begin
            mid_r <= mid_nxt;
            state_r <= S_SEL_CCMP;
          end else begin
            lo_r <= fbase;
            hi_r <= fmax;
            state_r <= S_SEL_F;
          end
        end
        S_SEL_CCMP: begin
          if (c_rd < qv_r) begin
            lo_r <= mid_r;
            ck_r <= c_rd;
          end else begin
            hi_r <= mid_r - 13'd1;
          end
          state_r <= S_SEL_C;
        end
        S_SEL_F: begin
          if (lo_r < hi_r) begin
            mid_r <= mid_nxt;
            state_r <= S_SEL_FCMP;
          end else begin
            state_r <= S_SEL_WRD;
          end
        end
        S_SEL_FCMP: begin
          if ((ck_r + {8'd0, f_rd}) < qv_r) begin
            lo_r <= mid_r;
            cf_r <= f_rd;
          end else begin
            hi_r <= mid_r - 13'd1;
          end
          state_r <= S_SEL_F;
        end
        S_SEL_WRD: state_r <= S_SEL_SCAN;
        S_SEL_SCAN: begin
          ans_r <= {lo_r, 3'd0} + {13'd0, nth_one(sc_byte, need_full[3:0])} + 16'd1;
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_ans_r <= ans_r;
            out_err_r <= err_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ones_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    ones_r <= len + 16'd32)
    else $error("one count exceeds bit length");

  a_words_cap: assert property (@(posedge clk) disable iff (!rst_n)
    words_r <= 11'(MAX_WORDS))
    else $error("word count beyond capacity");

  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("item accepted without starting work");

  a_resp_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && !out_valid_r) |=> out_valid_r && state_r == S_IDLE)
    else $error("result not presented");

endmodule
